// File: rtl/mprqs_pkg.sv
// ----------------------------------------------------------------------------
// mprqs_pkg
// Shared types and constants of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package mprqs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned SIDE_LIMIT_DEF  = 3;
  localparam logic [23:0] QUANTUM_MIN     = 24'd100;
  localparam logic [23:0] QUANTUM_RST     = 24'd1000;

  localparam logic [2:0] MODE_FCFS = 3'd0;
  localparam logic [2:0] MODE_SJF  = 3'd1;
  localparam logic [2:0] MODE_SRTF = 3'd2;
  localparam logic [2:0] MODE_EDF  = 3'd3;
  localparam logic [2:0] MODE_RR   = 3'd4;
  localparam logic [2:0] MODE_PRIO = 3'd5;

  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_HOLD   = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;

  localparam logic [1:0] STOP_NONE = 2'd0;
  localparam logic [1:0] STOP_FIN  = 2'd1;
  localparam logic [1:0] STOP_PRE  = 2'd2;
  localparam logic [1:0] STOP_DROP = 2'd3;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  job_id;
    logic        side;
    logic [23:0] service_ms;
    logic [23:0] remaining_ms;
    logic [31:0] deadline_ms;
    logic [7:0]  urgency;
    logic [15:0] arrival_seq;
    logic [9:0]  tick_ms;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        started_valid;
    logic [7:0]  started_id;
    logic [1:0]  stop_kind;
    logic [7:0]  stopped_id;
    logic [3:0]  ready_count;
    logic [15:0] completed_left;
    logic [15:0] completed_right;
    logic [15:0] completed_all;
    logic [31:0] wait_sum_ms;
    logic [31:0] turnaround_sum_ms;
    logic [31:0] service_sum_ms;
  } out_item_t;

  // One queued or active job.
  typedef struct packed {
    logic [7:0]  id;
    logic        side;
    logic [23:0] service;
    logic [23:0] remaining;
    logic [31:0] deadline;
    logic [7:0]  urgency;
    logic [15:0] arrival;
    logic [31:0] enq;
    logic        started;
    logic [31:0] start;
  } job_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the item, clear flags
    logic scan_step;  // examine entry scan index
    logic scan_clr;   // reset scan index and best
    logic insert_new; // insert new job at computed position
    logic insert_act_front;
    logic insert_act_back;
    logic drop_act;   // queue full on requeue
    logic start_best;
    logic finish;
    logic tick_upd;   // advance time and remaining
    logic clear_all;
    logic hold;
    logic resume;
    logic set_acc;
    logic emit;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [2:0] cmd;
    logic       scan_done;
    logic       enq_ok;
    logic       preempt;
    logic       act_valid;
    logic       act_zero;
    logic       rr_expire;
    logic       q_full;
    logic       q_empty;
  } sts_t;

endpackage

// File: rtl/mprqs_ctrl.sv
// ----------------------------------------------------------------------------
// mprqs_ctrl
// Sequencer that steps the datapath through the work of one command.
// ----------------------------------------------------------------------------
module mprqs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mprqs_pkg::sts_t sts,
  output mprqs_pkg::ctl_t ctl
);
  import mprqs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DISP   = 10'b0000000010,
    S_ESCAN  = 10'b0000000100,
    S_EINS   = 10'b0000001000,
    S_PRE    = 10'b0000010000,
    S_TICK   = 10'b0000100000,
    S_TDEC   = 10'b0001000000,
    S_BSCAN  = 10'b0010000000,
    S_BSTART = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ctl.scan_clr = 1'b1;
        case (sts.cmd)
          CMD_ENQ:    state_nxt = S_ESCAN;
          CMD_TICK:   state_nxt = S_TICK;
          CMD_CLEAR: begin
            ctl.clear_all = 1'b1;
            state_nxt = S_EMIT;
          end
          CMD_HOLD: begin
            ctl.hold = 1'b1;
            state_nxt = S_EMIT;
          end
          CMD_RESUME: begin
            ctl.resume = 1'b1;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      // Count same-side entries and find the insertion point.
      S_ESCAN: begin
        if (sts.scan_done) begin
          if (sts.enq_ok) begin
            ctl.insert_new = 1'b1;
            ctl.set_acc = 1'b1;
            state_nxt = S_PRE;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_EINS: state_nxt = S_EMIT;
      S_PRE: begin
        ctl.scan_clr = 1'b1;
        if (sts.act_valid && sts.preempt) begin
          if (sts.q_full) ctl.drop_act = 1'b1;
          else ctl.insert_act_front = 1'b1;
          state_nxt = S_BSCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_TICK: begin
        ctl.tick_upd = 1'b1;
        state_nxt = S_TDEC;
      end
      S_TDEC: begin
        ctl.scan_clr = 1'b1;
        if (sts.act_valid && sts.act_zero) begin
          ctl.finish = 1'b1;
          state_nxt = S_BSCAN;
        end else if (sts.act_valid && sts.rr_expire) begin
          if (sts.q_full) ctl.drop_act = 1'b1;
          else ctl.insert_act_back = 1'b1;
          state_nxt = S_BSCAN;
        end else if (!sts.act_valid) begin
          state_nxt = S_BSCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_BSCAN: begin
        if (sts.scan_done) state_nxt = S_BSTART;
        else ctl.scan_step = 1'b1;
      end
      S_BSTART: begin
        if (!sts.q_empty) ctl.start_best = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/mprqs_dp.sv
// ----------------------------------------------------------------------------
// mprqs_dp
// Queue registers, active job, scan unit, totals and result register.
// ----------------------------------------------------------------------------
module mprqs_dp #(
  parameter int unsigned QUEUE_DEPTH = mprqs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned SIDE_LIMIT  = mprqs_pkg::SIDE_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mprqs_pkg::in_item_t  in_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  mprqs_pkg::ctl_t      ctl,
  output mprqs_pkg::sts_t      sts,
  output logic                 out_strobe,
  output mprqs_pkg::out_item_t out_item
);
  import mprqs_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

  job_t           q_r [QUEUE_DEPTH];
  logic [LW-1:0]  len_r;
  in_item_t       it_r;
  logic [2:0]     mode_r;
  logic [23:0]    quant_r;
  logic           act_v_r, held_r;
  job_t           act_r;
  logic [31:0]    now_r, slice_r;
  logic [15:0]    cl_r, cr_r, ca_r;
  logic [31:0]    ws_r, ts_r, ss_r;
  logic [LW-1:0]  idx_r, pos_r, same_r;
  logic [IW-1:0]  best_r;
  logic           acc_r, sv_r;
  logic [7:0]     sid_r, xid_r;
  logic [1:0]     sk_r;
  out_item_t      out_r;
  logic           ostb_r;

  job_t           cur, bst, newj;
  logic           better;
  logic [IW-1:0]  cur_i;
  logic [23:0]    dec;

  assign cur_i = idx_r[IW-1:0];
  assign cur   = q_r[cur_i];
  assign bst   = q_r[best_r];

  always_comb begin
    better = 1'b0;
    case (mode_r)
      MODE_SJF:  better = (cur.service < bst.service) ||
                   (cur.service == bst.service && cur.arrival < bst.arrival);
      MODE_SRTF: better = cur.remaining < bst.remaining;
      MODE_EDF:  better = cur.deadline < bst.deadline;
      MODE_PRIO: better = (cur.urgency > bst.urgency) ||
                   (cur.urgency == bst.urgency && cur.arrival < bst.arrival);
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    newj = '0;
    newj.id = it_r.job_id;
    newj.side = it_r.side;
    newj.service = it_r.service_ms;
    newj.remaining = it_r.remaining_ms;
    newj.deadline = it_r.deadline_ms;
    newj.urgency = it_r.urgency;
    newj.arrival = it_r.arrival_seq;
    newj.enq = now_r;
  end

  assign dec = (act_r.remaining > 24'(it_r.tick_ms)) ? 24'(it_r.tick_ms) : act_r.remaining;

  always_comb begin
    sts.cmd       = it_r.cmd;
    sts.scan_done = (idx_r >= len_r);
    sts.enq_ok    = (len_r < LW'(QUEUE_DEPTH)) && (same_r < LW'(SIDE_LIMIT));
    case (mode_r)
      MODE_SRTF: sts.preempt = it_r.remaining_ms < act_r.remaining;
      MODE_EDF:  sts.preempt = it_r.deadline_ms < act_r.deadline;
      MODE_PRIO: sts.preempt = it_r.urgency > act_r.urgency;
      default:   sts.preempt = 1'b0;
    endcase
    sts.act_valid = act_v_r;
    sts.act_zero  = (act_r.remaining == '0);
    sts.rr_expire = (mode_r == MODE_RR) && (len_r != '0) &&
                    ((now_r - slice_r) >= 32'(quant_r));
    sts.q_full    = (len_r >= LW'(QUEUE_DEPTH));
    sts.q_empty   = (len_r == '0);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FCFS;
      quant_r <= QUANTUM_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) mode_r <= cfg_wdata[2:0];
      else quant_r <= (cfg_wdata < QUANTUM_MIN) ? QUANTUM_MIN : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) it_r <= in_item;
  end

  // Queue storage: shifts for insertion and removal.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ctl.insert_new) begin
        if (LW'(i) > pos_r && LW'(i) <= len_r) q_r[i] <= q_r[i-1];
        else if (LW'(i) == pos_r) q_r[i] <= newj;
      end else if (ctl.insert_act_front) begin
        if (i == 0) q_r[i] <= act_r;
        else if (LW'(i) <= len_r) q_r[i] <= q_r[i-1];
      end else if (ctl.insert_act_back) begin
        if (LW'(i) == len_r) q_r[i] <= act_r;
      end else if (ctl.start_best) begin
        if (i >= int'(best_r) && i < QUEUE_DEPTH - 1) q_r[i] <= q_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      act_v_r <= 1'b0;
      held_r  <= 1'b0;
      act_r   <= '0;
      now_r   <= '0;
      slice_r <= '0;
      cl_r <= '0; cr_r <= '0; ca_r <= '0;
      ws_r <= '0; ts_r <= '0; ss_r <= '0;
      idx_r <= '0; pos_r <= '0; same_r <= '0; best_r <= '0;
      acc_r <= 1'b0; sv_r <= 1'b0; sid_r <= '0; xid_r <= '0; sk_r <= STOP_NONE;
      ostb_r <= 1'b0;
    end else begin
      ostb_r <= ctl.emit;
      if (ctl.load) begin
        acc_r <= 1'b0; sv_r <= 1'b0; sid_r <= '0; xid_r <= '0; sk_r <= STOP_NONE;
      end
      if (ctl.scan_clr) begin
        idx_r  <= '0;
        best_r <= '0;
        pos_r  <= '0;
        same_r <= '0;
      end
      if (ctl.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (cur.side == it_r.side) same_r <= same_r + 1'b1;
        // The new job goes just after the last entry whose arrival number is
        // not larger than its own.
        if (cur.arrival <= it_r.arrival_seq) pos_r <= idx_r + 1'b1;
        if (idx_r != '0 && better) best_r <= cur_i;
      end
      if (ctl.insert_new) len_r <= len_r + 1'b1;
      if (ctl.set_acc) acc_r <= 1'b1;
      if (ctl.insert_act_front || ctl.insert_act_back || ctl.drop_act) begin
        len_r  <= (ctl.drop_act) ? len_r : len_r + 1'b1;
        xid_r  <= act_r.id;
        sk_r   <= ctl.drop_act ? STOP_DROP : STOP_PRE;
        act_v_r <= 1'b0;
        held_r <= 1'b0;
      end
      if (ctl.tick_upd) begin
        now_r <= now_r + 32'(it_r.tick_ms);
        if (act_v_r && !held_r) act_r.remaining <= act_r.remaining - dec;
      end
      if (ctl.finish) begin
        if (act_r.side) cr_r <= cr_r + 1'b1;
        else cl_r <= cl_r + 1'b1;
        ca_r <= ca_r + 1'b1;
        ws_r <= ws_r + (act_r.start - act_r.enq);
        ts_r <= ts_r + (now_r - act_r.enq);
        ss_r <= ss_r + 32'(act_r.service);
        sk_r <= STOP_FIN;
        xid_r <= act_r.id;
        act_v_r <= 1'b0;
        held_r <= 1'b0;
      end
      if (ctl.start_best) begin
        act_r <= bst;
        if (!bst.started) begin
          act_r.started <= 1'b1;
          act_r.start   <= now_r;
        end
        slice_r <= now_r;
        act_v_r <= 1'b1;
        held_r  <= 1'b0;
        len_r   <= len_r - 1'b1;
        sv_r    <= 1'b1;
        sid_r   <= bst.id;
      end
      if (ctl.clear_all) begin
        len_r <= '0; act_v_r <= 1'b0; held_r <= 1'b0; act_r <= '0; slice_r <= '0;
        cl_r <= '0; cr_r <= '0; ca_r <= '0; ws_r <= '0; ts_r <= '0; ss_r <= '0;
      end
      if (ctl.hold && act_v_r) held_r <= 1'b1;
      if (ctl.resume) held_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r.accepted          <= acc_r;
      out_r.started_valid     <= sv_r;
      out_r.started_id        <= sid_r;
      out_r.stop_kind         <= sk_r;
      out_r.stopped_id        <= xid_r;
      out_r.ready_count       <= 4'(len_r);
      out_r.completed_left    <= cl_r;
      out_r.completed_right   <= cr_r;
      out_r.completed_all     <= ca_r;
      out_r.wait_sum_ms       <= ws_r;
      out_r.turnaround_sum_ms <= ts_r;
      out_r.service_sum_ms    <= ss_r;
    end
  end

  assign out_strobe = ostb_r;
  assign out_item   = out_r;

endmodule

// File: rtl/multi_policy_ready_queue_scheduler_top.sv
// Between start and out_strobe the block scans the queue one entry a cycle
// (insertion point, then best job).
// Throughput: one item at a time; busy is high until the result is stored.
// Reset (rst_n low, synchronous) empties the queue and zeroes time and totals.
// The result is shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler_top
// Ready-queue scheduler with selectable policy and completion totals.
// ----------------------------------------------------------------------------
module multi_policy_ready_queue_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = mprqs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned SIDE_LIMIT  = mprqs_pkg::SIDE_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mprqs_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output mprqs_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_wdata
);
  import mprqs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mprqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  mprqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .SIDE_LIMIT(SIDE_LIMIT)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .ctl(ctl), .sts(sts), .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

// File: rtl/mprqs_checker.sv
// ----------------------------------------------------------------------------
// mprqs_checker
// Port-level checks of the scheduler's command and result behaviour.
// ----------------------------------------------------------------------------
module mprqs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input mprqs_pkg::out_item_t out_item
);
  import mprqs_pkg::*;

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item not taken");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result repeated");

  a_stop_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.stop_kind == STOP_NONE |-> out_item.stopped_id == 8'd0)
    else $error("stopped id without stop");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.completed_all ==
      out_item.completed_left + out_item.completed_right)
    else $error("completion totals differ");

endmodule

bind multi_policy_ready_queue_scheduler_top mprqs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item)
);

// File: tb/multi_policy_ready_queue_scheduler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler_top_test
// Drives command items into the scheduler under every policy and a range of quantum
// settings, predicts each result from a behavioural copy of the scheduler and
// compares every field of every result with the oldest prediction.
// ----------------------------------------------------------------------------
module multi_policy_ready_queue_scheduler_top_test;
  import mprqs_pkg::*;

  localparam int DEPTH = 8;
  localparam int SIDE_MAX = 3;
  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [23:0] cfg_wdata;

  multi_policy_ready_queue_scheduler_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow state of the scheduler.
  logic [2:0]  sch_mode;
  logic [23:0] sch_quantum;
  job_t        ready_q[$];
  logic        run_valid;
  job_t        run_job;
  logic        run_held;
  logic [31:0] slice_t0;
  logic [31:0] now_ms;
  logic [15:0] done_l, done_r, done_all;
  logic [31:0] wait_sum, turn_sum, serv_sum;

  out_item_t expected_q[$];
  int errors;
  int cycles;
  logic noidle;

  function automatic int best_index();
    int b;
    logic better;
    b = 0;
    for (int i = 1; i < ready_q.size(); i++) begin
      better = 1'b0;
      case (sch_mode)
        MODE_SJF: better = ready_q[i].service < ready_q[b].service ||
            (ready_q[i].service == ready_q[b].service &&
             ready_q[i].arrival < ready_q[b].arrival);
        MODE_SRTF: better = ready_q[i].remaining < ready_q[b].remaining;
        MODE_EDF: better = ready_q[i].deadline < ready_q[b].deadline;
        MODE_PRIO: better = ready_q[i].urgency > ready_q[b].urgency ||
            (ready_q[i].urgency == ready_q[b].urgency &&
             ready_q[i].arrival < ready_q[b].arrival);
        default: better = 1'b0;
      endcase
      if (better) b = i;
    end
    return b;
  endfunction

  task automatic start_best(inout out_item_t r);
    int b;
    job_t j;
    if (ready_q.size() == 0) return;
    b = best_index();
    j = ready_q[b];
    ready_q.delete(b);
    if (!j.started) begin
      j.started = 1'b1;
      j.start = now_ms;
    end
    slice_t0 = now_ms;
    run_job = j;
    run_valid = 1'b1;
    run_held = 1'b0;
    r.started_valid = 1'b1;
    r.started_id = j.id;
  endtask

  task automatic put_back(input logic front, inout out_item_t r);
    r.stopped_id = run_job.id;
    if (ready_q.size() >= DEPTH) begin
      r.stop_kind = STOP_DROP;
    end else begin
      if (front) ready_q.push_front(run_job);
      else ready_q.push_back(run_job);
      r.stop_kind = STOP_PRE;
    end
    run_valid = 1'b0;
    run_held = 1'b0;
  endtask

  task automatic clear_state();
    ready_q.delete();
    run_valid = 1'b0;
    run_held = 1'b0;
    run_job = '0;
    slice_t0 = '0;
    {done_l, done_r, done_all} = '0;
    {wait_sum, turn_sum, serv_sum} = '0;
  endtask

  task automatic schedule_item(input in_item_t it, output out_item_t r);
    job_t j;
    int same, pos;
    logic pre;
    r = '0;
    case (it.cmd)
      CMD_ENQ: begin
        j = '0;
        j.id = it.job_id;
        j.side = it.side;
        j.service = it.service_ms;
        j.remaining = it.remaining_ms;
        j.deadline = it.deadline_ms;
        j.urgency = it.urgency;
        j.arrival = it.arrival_seq;
        j.enq = now_ms;
        same = 0;
        foreach (ready_q[i]) if (ready_q[i].side == it.side) same++;
        if (ready_q.size() < DEPTH && same < SIDE_MAX) begin
          pos = ready_q.size();
          while (pos > 0 && ready_q[pos-1].arrival > j.arrival) pos--;
          ready_q.insert(pos, j);
          r.accepted = 1'b1;
          if (run_valid) begin
            pre = 1'b0;
            if (sch_mode == MODE_SRTF) pre = j.remaining < run_job.remaining;
            else if (sch_mode == MODE_EDF) pre = j.deadline < run_job.deadline;
            else if (sch_mode == MODE_PRIO) pre = j.urgency > run_job.urgency;
            if (pre) begin
              put_back(1'b1, r);
              start_best(r);
            end
          end
        end
      end
      CMD_TICK: begin
        now_ms = now_ms + it.tick_ms;
        if (run_valid) begin
          if (!run_held)
            run_job.remaining = run_job.remaining -
                ((it.tick_ms < run_job.remaining) ? it.tick_ms : run_job.remaining);
          if (run_job.remaining == 0) begin
            if (run_job.side) done_r++;
            else done_l++;
            done_all++;
            wait_sum += run_job.start - run_job.enq;
            turn_sum += now_ms - run_job.enq;
            serv_sum += run_job.service;
            r.stop_kind = STOP_FIN;
            r.stopped_id = run_job.id;
            run_valid = 1'b0;
            run_held = 1'b0;
          end else if (sch_mode == MODE_RR && ready_q.size() > 0 &&
                       now_ms - slice_t0 >= sch_quantum) begin
            put_back(1'b0, r);
            start_best(r);
          end
        end
        if (!run_valid && ready_q.size() > 0) start_best(r);
      end
      CMD_CLEAR: clear_state();
      CMD_HOLD: if (run_valid) run_held = 1'b1;
      CMD_RESUME: run_held = 1'b0;
      default: ;
    endcase
    r.ready_count = 4'(ready_q.size());
    r.completed_left = done_l;
    r.completed_right = done_r;
    r.completed_all = done_all;
    r.wait_sum_ms = wait_sum;
    r.turnaround_sum_ms = turn_sum;
    r.service_sum_ms = serv_sum;
  endtask

  // Result checker; the block cannot be held off, so sample every strobe.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else if (out_item !== expected_q[0]) begin
        $display("%0t: mismatch expected %p actual %p", $time, expected_q[0], out_item);
        errors++;
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) sch_mode = val[2:0];
    else sch_quantum = (val < QUANTUM_MIN) ? QUANTUM_MIN : val;
    @(posedge clk);
  endtask

  // Waits out every outstanding result, then lets the bench idle before going on.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  // Sends one item; the directed table may also give a result to compare.
  task automatic send_item(input in_item_t it, input logic has_fixed,
                           input out_item_t fixed);
    out_item_t r;
    if (!noidle) while ($urandom_range(99) < 17) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    schedule_item(it, r);
    if (has_fixed && r !== fixed) begin
      $display("%0t: prediction expected %p actual %p", $time, fixed, r);
      errors++;
    end
    expected_q.push_back(r);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t enq_item(logic [7:0] id, logic sd, logic [23:0] sv,
      logic [23:0] rm, logic [31:0] dl, logic [7:0] ur, logic [15:0] ar);
    in_item_t it;
    it = '0;
    it.cmd = CMD_ENQ;
    it.job_id = id;
    it.side = sd;
    it.service_ms = sv;
    it.remaining_ms = rm;
    it.deadline_ms = dl;
    it.urgency = ur;
    it.arrival_seq = ar;
    return it;
  endfunction

  function automatic in_item_t ctl_item(logic [2:0] c, logic [9:0] t);
    in_item_t it;
    it = in_item_t'(126'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    it.cmd = c;
    it.tick_ms = t;
    return it;
  endfunction

  function automatic in_item_t random_item(int pool);
    in_item_t it;
    int p;
    it = in_item_t'(126'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    p = $urandom_range(99);
    if (p < 45) begin
      it.cmd = CMD_ENQ;
      it.job_id = 8'($urandom_range(pool));
      if ($urandom_range(3) != 0) begin
        it.service_ms = 24'($urandom_range(3000));
        it.remaining_ms = 24'($urandom_range(2500));
        it.arrival_seq = 16'($urandom_range(200));
        it.deadline_ms = $urandom_range(5000);
        it.urgency = 8'($urandom_range(15));
      end
    end else if (p < 85) begin
      it.cmd = CMD_TICK;
    end else if (p < 91) begin
      it.cmd = CMD_HOLD;
    end else if (p < 96) begin
      it.cmd = CMD_RESUME;
    end else if (p < 98) begin
      it.cmd = 3'($urandom_range(7, 5));
    end else begin
      it.cmd = CMD_CLEAR;
    end
    return it;
  endfunction

  in_item_t dir_in[$];
  logic dir_has[$];
  out_item_t dir_out[$];

  task automatic add_row(input in_item_t it, input logic has, input out_item_t o);
    dir_in.push_back(it);
    dir_has.push_back(has);
    dir_out.push_back(o);
  endtask

  initial begin
    out_item_t o;
    errors = 0;
    cycles = 0;
    noidle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    sch_mode = MODE_FCFS;
    sch_quantum = QUANTUM_RST;
    now_ms = '0;
    clear_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset status, field extremes, every command and the
    // special cases (side limit, hold, unknown commands, clear).
    o = '0;
    add_row(ctl_item(CMD_TICK, 10'd0), 1'b1, o);
    add_row(ctl_item(CMD_HOLD, 10'd0), 1'b1, o);
    add_row(ctl_item(3'd7, 10'd0), 1'b1, o);
    o.accepted = 1'b1;
    o.ready_count = 4'd1;
    add_row(enq_item(8'hff, 1'b1, '1, '1, '1, 8'hff, 16'hffff), 1'b1, o);
    add_row(enq_item(8'h00, 1'b0, '0, '0, '0, 8'h00, 16'h0000), 1'b0, o);
    add_row(ctl_item(CMD_TICK, 10'd1023), 1'b0, o);
    add_row(enq_item(8'h11, 1'b1, 24'd5, 24'd5, 32'd9, 8'd3, 16'd5), 1'b0, o);
    add_row(enq_item(8'h12, 1'b1, 24'd6, 24'd7, 32'd9, 8'd3, 16'd5), 1'b0, o);
    add_row(enq_item(8'h13, 1'b1, 24'd6, 24'd7, 32'd9, 8'd3, 16'd5), 1'b0, o);
    add_row(enq_item(8'h21, 1'b0, 24'd50, 24'd40, 32'd1, 8'd9, 16'd2), 1'b0, o);
    add_row(enq_item(8'h22, 1'b0, 24'd50, 24'd40, 32'd1, 8'd9, 16'd2), 1'b0, o);
    add_row(enq_item(8'h23, 1'b0, 24'd50, 24'd40, 32'd1, 8'd9, 16'd2), 1'b0, o);
    add_row(enq_item(8'h24, 1'b0, 24'd50, 24'd40, 32'd1, 8'd9, 16'd2), 1'b0, o);
    add_row(ctl_item(CMD_HOLD, 10'd0), 1'b0, o);
    add_row(ctl_item(CMD_TICK, 10'd500), 1'b0, o);
    add_row(ctl_item(CMD_RESUME, 10'd0), 1'b0, o);
    add_row(ctl_item(CMD_TICK, 10'd7), 1'b0, o);
    add_row(ctl_item(3'd5, 10'd0), 1'b0, o);
    add_row(ctl_item(3'd6, 10'd0), 1'b0, o);
    o = '0;
    add_row(ctl_item(CMD_CLEAR, 10'd0), 1'b1, o);
    add_row(ctl_item(CMD_TICK, 10'd3), 1'b1, o);
    foreach (dir_in[i]) send_item(dir_in[i], dir_has[i], dir_out[i]);
    drain();

    // Random phases under every policy, including unused modes and the
    // quantum extremes.
    for (int ph = 0; ph < 9; ph++) begin
      logic [2:0] m;
      logic [23:0] qv;
      m = (ph < 8) ? 3'(ph) : MODE_RR;
      case (ph)
        4: qv = 24'd0;
        8: qv = 24'hffffff;
        default: qv = 24'($urandom_range(2000, 100));
      endcase
      write_reg(CFG_MODE, 24'(m));
      write_reg(CFG_QUANTUM, qv);
      noidle = (ph == 3);
      for (int n = 0; n < 150; n++) begin
        send_item(random_item((ph % 2) ? 255 : 15), 1'b0, '0);
        if (ph == 5 && n == 70) drain();
      end
      drain();
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
